/* rtl/core/rnfe_pkg.sv */
// Package for the RTCP NACK feedback expander.
// Holds the feedback type codes, the entry limit and the request type
// passed from the header walker to the expander. No dependencies.
package rnfe_pkg;

	// Generic NACK: transport feedback packet type and format.
	localparam logic [7:0] NACK_PT  = 8'd205;
	localparam logic [4:0] NACK_FMT = 5'd1;
	localparam logic [1:0] HDR_VERSION = 2'd2;

	// First FCI word sits at this word offset in a feedback packet.
	localparam logic [15:0] FCI_START = 16'd3;

	// Maximum FCI words expanded per sub-packet is MAX_NACK_ENTRIES + 1.
	localparam int MAX_NACK_ENTRIES = 64;
	localparam int FCI_LIMIT        = MAX_NACK_ENTRIES + 1;
	localparam int FCI_CNT_W        = $clog2(FCI_LIMIT + 1);

	localparam int SEQ_W  = 16;
	localparam int MASK_W = 16;
	localparam int IDX_W  = $clog2(MASK_W);

	// One FCI word to be expanded into lost sequence numbers.
	typedef struct packed {
		logic              expand;
		logic [SEQ_W-1:0]  pid;
		logic [MASK_W-1:0] mask;
		logic              vid;
	} nack_req_t;

endpackage

/* rtl/core/rnfe_parser.sv */
// Header walker for the RTCP NACK feedback expander.
// Tracks datagram and sub-packet position and flags FCI words to expand.
// Depends on rnfe_pkg.
module rnfe_parser import rnfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_fire,
	input  logic [31:0] packet_word,
	input  logic        last_word,
	input  logic        is_video,
	output nack_req_t   req
);

	logic                 first_q;
	logic                 ignored_q;
	logic [15:0]          offset_q;
	logic [15:0]          length_q;
	logic                 is_nack_q;
	logic [FCI_CNT_W-1:0] fci_cnt_q;

	logic                 ignored_eff;
	logic [15:0]          offset_eff;
	logic                 ignored_nxt;
	logic [15:0]          offset_nxt;
	logic [15:0]          length_nxt;
	logic                 is_nack_nxt;
	logic [FCI_CNT_W-1:0] fci_cnt_nxt;
	logic                 expand;

	// Decode the word against the current walk position.
	always_comb begin
		ignored_eff = ignored_q | (first_q & (packet_word[31:30] != HDR_VERSION));
		offset_eff  = first_q ? 16'd0 : offset_q;
		ignored_nxt = ignored_eff;
		offset_nxt  = offset_eff;
		length_nxt  = length_q;
		is_nack_nxt = is_nack_q;
		fci_cnt_nxt = fci_cnt_q;
		expand      = 1'b0;
		if (!ignored_eff) begin
			if (offset_eff == 16'd0) begin
				length_nxt  = packet_word[15:0];
				is_nack_nxt = (packet_word[23:16] == NACK_PT) &&
					(packet_word[28:24] == NACK_FMT);
				fci_cnt_nxt = '0;
				if (packet_word[15:0] == 16'd0) begin
					ignored_nxt = 1'b1;
				end else begin
					offset_nxt = 16'd1;
				end
			end else begin
				if (is_nack_q && (offset_eff >= FCI_START) &&
						(fci_cnt_q < FCI_CNT_W'(FCI_LIMIT))) begin
					expand      = 1'b1;
					fci_cnt_nxt = fci_cnt_q + 1'b1;
				end
				if (offset_eff >= length_q) begin
					offset_nxt = 16'd0;
				end else begin
					offset_nxt = offset_eff + 16'd1;
				end
			end
		end
	end

	assign req.expand = expand;
	assign req.pid    = packet_word[31:16];
	assign req.mask   = packet_word[15:0];
	assign req.vid    = is_video;

	// Walk state; the last word of a datagram returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= 1'b1;
			ignored_q <= 1'b0;
			offset_q  <= '0;
			length_q  <= '0;
			is_nack_q <= 1'b0;
			fci_cnt_q <= '0;
		end else if (word_fire) begin
			if (last_word) begin
				first_q   <= 1'b1;
				ignored_q <= 1'b0;
				offset_q  <= '0;
				length_q  <= '0;
				is_nack_q <= 1'b0;
				fci_cnt_q <= '0;
			end else begin
				first_q   <= 1'b0;
				ignored_q <= ignored_nxt;
				offset_q  <= offset_nxt;
				length_q  <= length_nxt;
				is_nack_q <= is_nack_nxt;
				fci_cnt_q <= fci_cnt_nxt;
			end
		end
	end

endmodule

/* rtl/core/rnfe_expander.sv */
// Expander for the RTCP NACK feedback expander. Depends on rnfe_pkg.
// Holds one FCI word and emits its packet id and one number per set mask
// bit, one per cycle unless the output stalls, into an output register.
module rnfe_expander import rnfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  nack_req_t        req,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SEQ_W-1:0] lost_seq,
	output logic             seq_is_video,
	output logic             run_end
);

	logic              busy_q;
	logic              head_q;
	logic [SEQ_W-1:0]  pid_q;
	logic [MASK_W-1:0] mask_q;
	logic              vid_q;

	logic              out_valid_q;
	logic [SEQ_W-1:0]  seq_q;
	logic              vid_out_q;
	logic              end_q;

	logic              emit;
	logic [IDX_W-1:0]  low_idx;
	logic [MASK_W-1:0] mask_left;
	logic [SEQ_W-1:0]  seq_val;
	logic              last_val;

	// Lowest set bit of the remaining mask.
	always_comb begin
		low_idx = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_idx = IDX_W'(i);
			end
		end
	end

	// Next number: the packet id first, then pid + i + 1 per set bit.
	always_comb begin
		if (head_q) begin
			mask_left = mask_q;
			seq_val   = pid_q;
		end else begin
			mask_left = mask_q & (mask_q - 1'b1);
			seq_val   = pid_q + SEQ_W'(low_idx) + SEQ_W'(1);
		end
		last_val = (mask_left == '0);
	end

	assign emit     = busy_q && (!out_valid_q || out_ready);
	assign can_load = !busy_q || (emit && last_val);

	// Word being expanded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			head_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
			head_q <= 1'b1;
		end else if (emit) begin
			busy_q <= !last_val;
			head_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pid_q  <= req.pid;
			mask_q <= req.mask;
			vid_q  <= req.vid;
		end else if (emit) begin
			mask_q <= mask_left;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			seq_q     <= seq_val;
			vid_out_q <= vid_q;
			end_q     <= last_val;
		end
	end

	assign out_valid    = out_valid_q;
	assign lost_seq     = seq_q;
	assign seq_is_video = vid_out_q;
	assign run_end      = end_q;

endmodule

/* rtl/core/rtcp_nack_feedback_expander_unit.sv */
// Top level of the RTCP NACK feedback expander.
// Takes compound RTCP datagrams word by word and reports lost sequence numbers.
// Depends on rnfe_pkg, rnfe_parser and rnfe_expander.
//
// Input channel: one request per 32-bit datagram word (packet_word, big-endian
// value), with last_word on the final word and is_video for the stream kind.
// Output channel: one request per lost sequence number, with the stream kind
// and run_end on the last number produced by a given input word.
// Header walking happens as a word is accepted, so words that produce no
// numbers are taken one per cycle while the expander is idle. An FCI word of
// a generic NACK produces 1 + popcount(mask) numbers, at most 17; the
// expander emits one per cycle while the output is not stalled and holds
// in_ready low until the last of them leaves the expander.
// An FCI word is loaded into the expander register as it is accepted, and
// each of its numbers then passes through the output register.
// When out_ready is low and the output register is full, it holds and the
// expander stalls, which in turn stalls the input. Reset clears the walk
// state and empties both registers; the next word is taken as the start of
// a datagram.
module rtcp_nack_feedback_expander_unit import rnfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [31:0]      packet_word,
	input  logic             last_word,
	input  logic             is_video,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SEQ_W-1:0] lost_seq,
	output logic             seq_is_video,
	output logic             run_end
);

	nack_req_t req;
	logic      can_load;
	logic      word_fire;

	assign in_ready  = can_load;
	assign word_fire = in_valid && can_load;

	// Datagram and sub-packet header walk.
	rnfe_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_fire   (word_fire),
		.packet_word (packet_word),
		.last_word   (last_word),
		.is_video    (is_video),
		.req         (req)
	);

	// Mask expansion and output register.
	rnfe_expander u_expander (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (word_fire && req.expand),
		.req          (req),
		.can_load     (can_load),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.lost_seq     (lost_seq),
		.seq_is_video (seq_is_video),
		.run_end      (run_end)
	);

endmodule

/* tb/rnfe_lost_seq_checker.sv */
`timescale 1ns / 1ps
// Checker for the RTCP NACK expander: tracks the header walk, predicts lost sequence
// numbers and compares them with the output channel. Depends on rnfe_pkg.
module rnfe_lost_seq_checker import rnfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [31:0]      packet_word,
	input  logic             last_word,
	input  logic             is_video,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [SEQ_W-1:0] lost_seq,
	input  logic             seq_is_video,
	input  logic             run_end,
	output int               mismatches,
	output int               pending
);

	// One expected lost sequence number.
	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic             vid;
		logic             tail;
	} lost_entry_t;

	localparam int PRINT_CAP = 100;

	lost_entry_t            lost_q[$];
	logic                   at_dgram_start;
	logic                   dgram_dropped;
	logic [15:0]            word_pos;
	logic [15:0]            sub_len;
	logic                   sub_is_nack;
	logic [FCI_CNT_W-1:0]   fci_seen;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report(input string what);
		if (mismatches < PRINT_CAP)
			$display("[%0t] %s", $time, what);
		mismatches++;
	endtask

	// Puts the walk back to the state of a fresh datagram.
	task automatic clear_walk();
		at_dgram_start = 1'b1;
		dgram_dropped = 1'b0;
		word_pos = '0;
		sub_len = '0;
		sub_is_nack = 1'b0;
		fci_seen = '0;
	endtask

	// Advances the header walk by one accepted word and queues the numbers it yields.
	task automatic predict_word(input logic [31:0] w, input logic last, input logic vid);
		logic [SEQ_W-1:0]  pid;
		logic [MASK_W-1:0] mask;
		if (at_dgram_start) begin
			at_dgram_start = 1'b0;
			word_pos = '0;
			if (w[31:30] != HDR_VERSION)
				dgram_dropped = 1'b1;
		end
		if (!dgram_dropped) begin
			if (word_pos == 0) begin
				// A sub-packet header; a zero length ends the walk.
				sub_len = w[15:0];
				sub_is_nack = (w[23:16] == NACK_PT) && (w[28:24] == NACK_FMT);
				fci_seen = '0;
				if (sub_len == 0)
					dgram_dropped = 1'b1;
				else
					word_pos = 16'd1;
			end else begin
				// FCI words expand into the packet id and one number per set mask bit.
				if (sub_is_nack && word_pos >= FCI_START && fci_seen < FCI_LIMIT) begin
					pid = w[31:16];
					mask = w[15:0];
					lost_q.push_back('{pid, vid, mask == 0});
					for (int i = 0; i < MASK_W; i++) begin
						if (mask[i])
							lost_q.push_back('{pid + 16'(i + 1), vid,
								(mask >> (i + 1)) == 0});
					end
					fci_seen++;
				end
				if (word_pos >= sub_len)
					word_pos = '0;
				else
					word_pos++;
			end
		end
		if (last)
			clear_walk();
	endtask

	// Compares one accepted output request with the oldest expectation.
	task automatic check_result();
		lost_entry_t want;
		if (lost_q.size() == 0) begin
			report($sformatf("unexpected result lost_seq=%h with nothing pending", lost_seq));
		end else begin
			want = lost_q.pop_front();
			if (lost_seq !== want.seq)
				report($sformatf("lost_seq got %h, wanted %h", lost_seq, want.seq));
			if (seq_is_video !== want.vid)
				report($sformatf("seq_is_video got %b, wanted %b for seq %h",
					seq_is_video, want.vid, want.seq));
			if (run_end !== want.tail)
				report($sformatf("run_end got %b, wanted %b for seq %h",
					run_end, want.tail, want.seq));
		end
	endtask

	// Both channels are sampled at the clock edge that accepts a request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_walk();
			lost_q.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				predict_word(packet_word, last_word, is_video);
			pending = lost_q.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the RTCP NACK expander testbench: clock, reset, datagram stimulus and verdict.
// Depends on rnfe_pkg, rtcp_nack_feedback_expander_unit and rnfe_lost_seq_checker.
module testbench import rnfe_pkg::*; ();

	localparam logic [7:0] PT_PSFB          = 8'd206;
	localparam int         ITEM_TARGET      = 320;
	localparam int         HOLD_AFTER_WORDS = 120;
	localparam int         HOLD_CYCLES      = 400;
	localparam int         DRAIN_CYCLES     = 20;

	typedef enum {DG_WELL, DG_TRUNC, DG_ZERO, DG_NOISE, DG_LONG} dgram_kind_t;
	typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_CADENCE} rx_mode_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [31:0]      packet_word;
	logic             last_word;
	logic             is_video;
	logic             out_valid;
	logic             out_ready;
	logic [SEQ_W-1:0] lost_seq;
	logic             seq_is_video;
	logic             run_end;
	int               mismatches;
	int               pending;
	int               words_sent;
	int               burst_left;
	logic [31:0]      dgram[$];

	rtcp_nack_feedback_expander_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packet_word  (packet_word),
		.last_word    (last_word),
		.is_video     (is_video),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.lost_seq     (lost_seq),
		.seq_is_video (seq_is_video),
		.run_end      (run_end)
	);

	rnfe_lost_seq_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packet_word  (packet_word),
		.last_word    (last_word),
		.is_video     (is_video),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.lost_seq     (lost_seq),
		.seq_is_video (seq_is_video),
		.run_end      (run_end),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [31:0] rtcp_header(input logic [1:0] ver, input logic pad,
		input logic [4:0] fmt, input logic [7:0] pt, input logic [15:0] len);
		return {ver, pad, fmt, pt, len};
	endfunction

	// FCI word with a mask drawn from several densities; sparse keeps long runs quick.
	function automatic logic [31:0] fci_word(input bit sparse);
		logic [15:0] mask;
		if (sparse) begin
			mask = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0000;
		end else begin
			case ($urandom_range(0, 5))
				0: mask = 16'h0000;
				1: mask = 16'hFFFF;
				2: mask = 16'h0001 << $urandom_range(0, 15);
				default: mask = 16'($urandom);
			endcase
		end
		return {16'($urandom), mask};
	endfunction

	// Later headers get an unchecked version now and then; the first is always valid.
	task automatic push_header(input logic [4:0] fmt, input logic [7:0] pt,
		input logic [15:0] len);
		logic [1:0] ver;
		ver = (dgram.size() == 0 || $urandom_range(0, 3) != 0) ? HDR_VERSION : 2'($urandom);
		dgram.push_back(rtcp_header(ver, 1'($urandom), fmt, pt, len));
	endtask

	task automatic push_nack(input int nfci, input bit sparse);
		push_header(NACK_FMT, NACK_PT, 16'(nfci + 2));
		repeat (2) dgram.push_back($urandom);
		repeat (nfci) dgram.push_back(fci_word(sparse));
	endtask

	// Feedback that is not a generic NACK, often off by only the type or the format.
	task automatic push_other();
		logic [4:0] fmt;
		logic [7:0] pt;
		int len;
		fmt = 5'($urandom);
		pt = 8'($urandom);
		case ($urandom_range(0, 2))
			0: pt = NACK_PT;
			1: fmt = NACK_FMT;
			default: ;
		endcase
		if (pt == NACK_PT && fmt == NACK_FMT)
			pt = PT_PSFB;
		len = $urandom_range(1, 4);
		push_header(fmt, pt, 16'(len));
		repeat (len) dgram.push_back(fci_word(1'b0));
	endtask

	// Fills the datagram buffer with one compound packet of the given kind.
	task automatic build_datagram(input dgram_kind_t kind);
		int subs;
		int zero_at;
		int len;
		int cut;
		dgram.delete();
		if (kind == DG_NOISE) begin
			repeat ($urandom_range(1, 5)) dgram.push_back($urandom);
		end else if (kind == DG_LONG) begin
			push_nack($urandom_range(FCI_LIMIT + 1, FCI_LIMIT + 5), 1'b1);
		end else begin
			subs = $urandom_range(1, 3);
			zero_at = (kind == DG_ZERO) ? $urandom_range(0, subs) : -1;
			for (int s = 0; s <= subs; s++) begin
				if (s == zero_at)
					push_header(5'($urandom), 8'($urandom), 16'd0);
				if (s == subs)
					break;
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						// NACK too short to carry FCI words.
						len = $urandom_range(1, 2);
						push_header(NACK_FMT, NACK_PT, 16'(len));
						repeat (len) dgram.push_back(fci_word(1'b0));
					end
					3, 4, 5: push_other();
					default: push_nack(($urandom_range(0, 9) == 0) ? $urandom_range(5, 16)
						: $urandom_range(0, 4), 1'b0);
				endcase
			end
			if (kind == DG_ZERO)
				repeat ($urandom_range(1, 3)) dgram.push_back(fci_word(1'b0));
			if (kind == DG_TRUNC && dgram.size() > 1) begin
				cut = $urandom_range(1, dgram.size() - 1);
				while (dgram.size() > cut)
					void'(dgram.pop_back());
			end
		end
	endtask

	// Offers one request; bursts of random length are separated by random gaps.
	task automatic offer_word(input logic [31:0] w, input logic last, input logic vid);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48)
				: $urandom_range(1, 8);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		packet_word <= w;
		last_word <= last;
		is_video <= vid;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
		burst_left--;
	endtask

	task automatic send_datagram(input logic vid);
		foreach (dgram[i])
			offer_word(dgram[i], i == dgram.size() - 1, vid);
	endtask

	// Receiver: stall pattern is redrawn periodically from four modes, with one long hold mid-run.
	initial begin : receiver
		rx_mode_t mode;
		int cyc;
		int hold;
		bit held;
		out_ready = 1'b0;
		mode = RX_OPEN;
		cyc = 0;
		hold = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && words_sent >= HOLD_AFTER_WORDS) begin
				held = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (cyc % 64 == 0)
				mode = rx_mode_t'($urandom_range(0, 3));
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_HALF:   out_ready <= 1'($urandom);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (cyc % 3) != 0;
				endcase
			end
		end
	end

	initial begin : stimulus
		dgram_kind_t kind;
		int pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		packet_word = '0;
		last_word = 1'b0;
		is_video = 1'b0;
		words_sent = 0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Full mask at the top packet id wraps past zero; a zero length then ends the walk.
		dgram = '{rtcp_header(HDR_VERSION, 1'b0, NACK_FMT, NACK_PT, 16'd3),
			32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			rtcp_header(HDR_VERSION, 1'b0, NACK_FMT, NACK_PT, 16'd0), 32'h0001_0001};
		send_datagram(1'b1);

		// Wrong version on the first header drops the whole datagram.
		dgram = '{rtcp_header(2'd1, 1'b0, NACK_FMT, NACK_PT, 16'd3),
			32'h0000_0000, 32'h0000_0000, 32'h0005_0003};
		send_datagram(1'b0);

		// Short NACK, then other feedback, then a padded NACK with two FCI words.
		dgram = '{rtcp_header(HDR_VERSION, 1'b0, NACK_FMT, NACK_PT, 16'd2),
			32'h0202_0202, 32'h0033_0007,
			rtcp_header(HDR_VERSION, 1'b0, NACK_FMT, PT_PSFB, 16'd2),
			32'h1111_1111, 32'h0100_00FF,
			rtcp_header(HDR_VERSION, 1'b1, NACK_FMT, NACK_PT, 16'd4),
			32'hAAAA_5555, 32'h5555_AAAA, 32'h0000_0000, 32'h1234_8001};
		send_datagram(1'b1);

		// Datagram cut short inside a NACK of the largest length.
		dgram = '{rtcp_header(HDR_VERSION, 1'b0, NACK_FMT, NACK_PT, 16'hFFFF),
			32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000};
		send_datagram(1'b0);

		// One NACK past the entry limit, then a mix led by well-formed datagrams.
		build_datagram(DG_LONG);
		send_datagram(1'($urandom));
		while (words_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 39);
			if (pick == 0)
				kind = DG_LONG;
			else if (pick <= 3)
				kind = DG_NOISE;
			else if (pick <= 6)
				kind = DG_TRUNC;
			else if (pick <= 9)
				kind = DG_ZERO;
			else
				kind = DG_WELL;
			build_datagram(kind);
			send_datagram(1'($urandom));
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
